FILE: hw/rtl/cbcr_pkg.sv
// Shared types, widths and helpers for the circle/box collision resolver.
package cbcr_pkg;

   localparam int FRAC        = 8;
   localparam int RAD_W       = 10;
   localparam int BALL_W      = 24;
   localparam int EDGE_W      = 16;
   localparam int OUT_W       = 24;
   localparam int W           = EDGE_W + FRAC + 4;
   localparam int RQ_W        = RAD_W + FRAC;
   localparam int D2_W        = 2 * RQ_W + 1;
   localparam int SQ_IN_W     = 2 * ((D2_W + 1) / 2);
   localparam int SQRT_STEPS  = SQ_IN_W / 2;
   localparam int DIST_W      = SQRT_STEPS;
   localparam int SQ_REM_W    = DIST_W + 2;
   localparam int NUM_W       = 2 * RQ_W;
   localparam int DIV_STEPS   = RQ_W;
   localparam int LATENCY     = 6 + SQRT_STEPS + DIV_STEPS;
   localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(50);

   typedef struct packed {
      logic signed [BALL_W-1:0] ball_x;
      logic signed [BALL_W-1:0] ball_y;
      logic signed [EDGE_W-1:0] box_left;
      logic signed [EDGE_W-1:0] box_right;
      logic signed [EDGE_W-1:0] box_top;
      logic signed [EDGE_W-1:0] box_bottom;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic signed [OUT_W-1:0] push_x;
      logic signed [OUT_W-1:0] push_y;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic                hit;
      logic                in_box;
      logic                sx;
      logic                sy;
      logic [RQ_W-1:0]     adx;
      logic [RQ_W-1:0]     ady;
      logic [RQ_W-1:0]     rq;
      logic signed [W-1:0] ipx;
      logic signed [W-1:0] ipy;
   } side_type;

   typedef struct packed {
      side_type              side;
      logic [SQ_REM_W-1:0]   rem;
      logic [DIST_W-1:0]     q;
      logic [SQ_IN_W-1:0]    v;
   } sq_type;

   typedef struct packed {
      side_type            side;
      logic [DIST_W-1:0]   dvsr;
      logic [DIST_W-1:0]   remx;
      logic [DIST_W-1:0]   remy;
      logic [RQ_W-1:0]     nx;
      logic [RQ_W-1:0]     ny;
      logic [RQ_W-1:0]     qx;
      logic [RQ_W-1:0]     qy;
   } dv_type;

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
      mag = v[W-1] ? W'(-v) : W'(v);
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [W-1:0] v);
      logic signed [W-1:0] hi;
      logic signed [W-1:0] lo;
      hi = W'(signed'({1'b0, {(OUT_W-1){1'b1}}}));
      lo = -hi - W'(1);
      if (v > hi)
         sat_out = {1'b0, {(OUT_W-1){1'b1}}};
      else if (v < lo)
         sat_out = {1'b1, {(OUT_W-1){1'b0}}};
      else
         sat_out = v[OUT_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/circle_box_collision_resolve.sv
// Top level: circle/box collision test and push-out vector, fully pipelined.
//
//  channel   ports                            beat taken when
//  request   start, busy, req_data            start & !busy
//  response  rsp_strobe, rsp_data             rsp_strobe (one cycle, no stall)
//  csr       csr_valid, csr_ready, csr_wdata  csr_valid & csr_ready
//
// One beat per cycle in, one result per beat out, through 43 register stages:
// 2 front stages, squares, 19 square-root cells (radius compare ahead of the
// first), gap, products, 18 divider cells and the output register.
// busy stays low. Synchronous reset clears all valids; radius resets to 50.
// The response side cannot stall; results leave on the strobe cycle.
module circle_box_collision_resolve (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  cbcr_pkg::req_type             req_data,
   output logic                          rsp_strobe,
   output cbcr_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cbcr_pkg::RAD_W-1:0]    csr_wdata
);
   import cbcr_pkg::*;

   logic [RAD_W-1:0]   radius_ff, radius_in;
   side_type           fr_side;
   side_type           ms_ff, ms_in;
   logic [NUM_W-1:0]   sqx_ff, sqx_in, sqy_ff, sqy_in, r2_ff, r2_in;
   sq_type             sq [SQRT_STEPS+1];
   logic [D2_W-1:0]    d2;
   side_type           gp_ff, gp_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [RQ_W-1:0]    gap_ff, gap_in;
   side_type           pr_ff, pr_in;
   logic [DIST_W-1:0]  pdist_ff, pdist_in;
   logic [NUM_W-1:0]   numx_ff, numx_in, numy_ff, numy_in;
   dv_type             dv [DIV_STEPS+1];
   logic               strobe_ff, strobe_in;
   rsp_type            rsp_ff, rsp_in;
   side_type           ls;
   logic signed [W-1:0] qx_s, qy_s;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign radius_in = (csr_valid && csr_ready) ? csr_wdata : radius_ff;

   cbcr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .load   (start && !busy),
      .req    (req_data),
      .radius (radius_ff),
      .side   (fr_side)
   );

   always_comb begin
      ms_in  = fr_side;
      sqx_in = fr_side.adx * fr_side.adx;
      sqy_in = fr_side.ady * fr_side.ady;
      r2_in  = fr_side.rq * fr_side.rq;
   end

   always_comb begin
      d2               = D2_W'(sqx_ff) + D2_W'(sqy_ff);
      sq[0].side       = ms_ff;
      sq[0].side.hit   = ms_ff.hit && (d2 < D2_W'(r2_ff));
      sq[0].rem        = '0;
      sq[0].q          = '0;
      sq[0].v          = SQ_IN_W'(d2);
   end

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      cbcr_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .din   (sq[i]),
         .dout  (sq[i+1])
      );
   end

   always_comb begin
      gp_in   = sq[SQRT_STEPS].side;
      dist_in = sq[SQRT_STEPS].q;
      gap_in  = RQ_W'((DIST_W+1)'(sq[SQRT_STEPS].side.rq) - (DIST_W+1)'(sq[SQRT_STEPS].q));
   end

   always_comb begin
      pr_in    = gp_ff;
      pdist_in = dist_ff;
      numx_in  = gp_ff.adx * gap_ff;
      numy_in  = gp_ff.ady * gap_ff;
   end

   always_comb begin
      dv[0].side = pr_ff;
      dv[0].dvsr = pdist_ff;
      dv[0].remx = DIST_W'(numx_ff[NUM_W-1 -: RQ_W]);
      dv[0].remy = DIST_W'(numy_ff[NUM_W-1 -: RQ_W]);
      dv[0].nx   = numx_ff[RQ_W-1:0];
      dv[0].ny   = numy_ff[RQ_W-1:0];
      dv[0].qx   = '0;
      dv[0].qy   = '0;
   end

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      cbcr_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .din   (dv[i]),
         .dout  (dv[i+1])
      );
   end

   always_comb begin
      ls        = dv[DIV_STEPS].side;
      qx_s      = W'(dv[DIV_STEPS].qx);
      qy_s      = W'(dv[DIV_STEPS].qy);
      strobe_in = ls.valid;
      rsp_in.hit = ls.hit;
      priority if (!ls.hit) begin
         rsp_in.push_x = '0;
         rsp_in.push_y = '0;
      end else if (ls.in_box) begin
         rsp_in.push_x = sat_out(ls.ipx);
         rsp_in.push_y = sat_out(ls.ipy);
      end else begin
         rsp_in.push_x = sat_out(ls.sx ? -qx_s : qx_s);
         rsp_in.push_y = sat_out(ls.sy ? -qy_s : qy_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         ms_ff.valid <= 1'b0;
         gp_ff.valid <= 1'b0;
         pr_ff.valid <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         radius_ff <= radius_in;
         ms_ff.valid <= ms_in.valid;
         gp_ff.valid <= gp_in.valid;
         pr_ff.valid <= pr_in.valid;
         strobe_ff   <= strobe_in;
      end
      {ms_ff.hit, ms_ff.in_box, ms_ff.sx, ms_ff.sy, ms_ff.adx, ms_ff.ady, ms_ff.rq,
       ms_ff.ipx, ms_ff.ipy} <=
      {ms_in.hit, ms_in.in_box, ms_in.sx, ms_in.sy, ms_in.adx, ms_in.ady, ms_in.rq,
       ms_in.ipx, ms_in.ipy};
      {gp_ff.hit, gp_ff.in_box, gp_ff.sx, gp_ff.sy, gp_ff.adx, gp_ff.ady, gp_ff.rq,
       gp_ff.ipx, gp_ff.ipy} <=
      {gp_in.hit, gp_in.in_box, gp_in.sx, gp_in.sy, gp_in.adx, gp_in.ady, gp_in.rq,
       gp_in.ipx, gp_in.ipy};
      {pr_ff.hit, pr_ff.in_box, pr_ff.sx, pr_ff.sy, pr_ff.adx, pr_ff.ady, pr_ff.rq,
       pr_ff.ipx, pr_ff.ipy} <=
      {pr_in.hit, pr_in.in_box, pr_in.sx, pr_in.sy, pr_in.adx, pr_in.ady, pr_in.rq,
       pr_in.ipx, pr_in.ipy};
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      r2_ff    <= r2_in;
      dist_ff  <= dist_in;
      gap_ff   <= gap_in;
      pdist_ff <= pdist_in;
      numx_ff  <= numx_in;
      numy_ff  <= numy_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("response without a matching request");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.hit) |-> (rsp_data.push_x == '0 && rsp_data.push_y == '0))
      else $error("push on a miss");

   a_hit_near : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.hit) |-> $past(fr_side.hit, LATENCY - 2))
      else $error("hit without near offsets");

endmodule

FILE: hw/rtl/cbcr_front.sv
// Front end: centre, clamp, axis offsets and inside-box push, two stages.
module cbcr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  cbcr_pkg::req_type             req,
   input  logic [cbcr_pkg::RAD_W-1:0]    radius,
   output cbcr_pkg::side_type            side
);
   import cbcr_pkg::*;

   logic                v1_ff, v1_in;
   logic signed [W-1:0] mx_ff, mx_in, my_ff, my_in;
   logic signed [W-1:0] bl_ff, bl_in, br_ff, br_in, bt_ff, bt_in, bb_ff, bb_in;
   logic [RQ_W-1:0]     rq_ff, rq_in;
   side_type            side_ff, side_in;

   logic signed [W-1:0] rqs, fx, fy, dx, dy, lf, rt, tp, bm, px, py;
   logic [W-1:0]        adx, ady, apx, apy;

   always_comb begin
      rq_in = {radius, {FRAC{1'b0}}};
      v1_in = load;
      mx_in = {{(W-BALL_W){req.ball_x[BALL_W-1]}}, req.ball_x} + W'(rq_in);
      my_in = {{(W-BALL_W){req.ball_y[BALL_W-1]}}, req.ball_y} + W'(rq_in);
      bl_in = {{(W-EDGE_W-FRAC){req.box_left[EDGE_W-1]}}, req.box_left, {FRAC{1'b0}}};
      br_in = {{(W-EDGE_W-FRAC){req.box_right[EDGE_W-1]}}, req.box_right, {FRAC{1'b0}}};
      bt_in = {{(W-EDGE_W-FRAC){req.box_top[EDGE_W-1]}}, req.box_top, {FRAC{1'b0}}};
      bb_in = {{(W-EDGE_W-FRAC){req.box_bottom[EDGE_W-1]}}, req.box_bottom, {FRAC{1'b0}}};
   end

   always_comb begin
      rqs = W'(rq_ff);
      priority if (mx_ff < bl_ff) fx = bl_ff;
      else if (mx_ff > br_ff)     fx = br_ff;
      else                        fx = mx_ff;
      priority if (my_ff < bt_ff) fy = bt_ff;
      else if (my_ff > bb_ff)     fy = bb_ff;
      else                        fy = my_ff;
      dx  = mx_ff - fx;
      dy  = my_ff - fy;
      adx = mag(dx);
      ady = mag(dy);
      lf  = mx_ff - bl_ff + rqs;
      rt  = br_ff - mx_ff + rqs;
      tp  = my_ff - bt_ff + rqs;
      bm  = bb_ff - my_ff + rqs;
      px  = (lf < rt) ? -lf : rt;
      py  = (tp < bm) ? -tp : bm;
      apx = mag(px);
      apy = mag(py);
      side_in.valid  = v1_ff;
      side_in.hit    = (adx < W'(rq_ff)) && (ady < W'(rq_ff));
      side_in.in_box = (dx == '0) && (dy == '0);
      side_in.sx     = dx[W-1];
      side_in.sy     = dy[W-1];
      side_in.adx    = adx[RQ_W-1:0];
      side_in.ady    = ady[RQ_W-1:0];
      side_in.rq     = rq_ff;
      side_in.ipx    = (apx > apy) ? '0 : px;
      side_in.ipy    = (apx < apy) ? '0 : py;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         side_ff.valid <= 1'b0;
      end else begin
         v1_ff         <= v1_in;
         side_ff.valid <= side_in.valid;
      end
      mx_ff <= mx_in;
      my_ff <= my_in;
      bl_ff <= bl_in;
      br_ff <= br_in;
      bt_ff <= bt_in;
      bb_ff <= bb_in;
      rq_ff <= rq_in;
      {side_ff.hit, side_ff.in_box, side_ff.sx, side_ff.sy, side_ff.adx, side_ff.ady,
       side_ff.rq, side_ff.ipx, side_ff.ipy} <=
      {side_in.hit, side_in.in_box, side_in.sx, side_in.sy, side_in.adx, side_in.ady,
       side_in.rq, side_in.ipx, side_in.ipy};
   end

   assign side = side_ff;

endmodule

FILE: hw/rtl/cbcr_sqrt_cell.sv
// One root digit of the pipelined square root.
module cbcr_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  cbcr_pkg::sq_type  din,
   output cbcr_pkg::sq_type  dout
);
   import cbcr_pkg::*;

   sq_type                  cell_ff, cell_in;
   logic [SQ_REM_W+1:0]     t;
   logic [SQ_REM_W+1:0]     trial;
   logic                    ge;

   always_comb begin
      t       = {din.rem, din.v[SQ_IN_W-1 -: 2]};
      trial   = (SQ_REM_W+2)'({din.q, 2'b01});
      ge      = t >= trial;
      cell_in.side = din.side;
      cell_in.rem  = ge ? SQ_REM_W'(t - trial) : SQ_REM_W'(t);
      cell_in.q    = {din.q[DIST_W-2:0], ge};
      cell_in.v    = {din.v[SQ_IN_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.side.valid <= 1'b0;
      end else begin
         cell_ff.side.valid <= cell_in.side.valid;
      end
      cell_ff.side.hit    <= cell_in.side.hit;
      cell_ff.side.in_box <= cell_in.side.in_box;
      cell_ff.side.sx     <= cell_in.side.sx;
      cell_ff.side.sy     <= cell_in.side.sy;
      cell_ff.side.adx    <= cell_in.side.adx;
      cell_ff.side.ady    <= cell_in.side.ady;
      cell_ff.side.rq     <= cell_in.side.rq;
      cell_ff.side.ipx    <= cell_in.side.ipx;
      cell_ff.side.ipy    <= cell_in.side.ipy;
      cell_ff.rem         <= cell_in.rem;
      cell_ff.q           <= cell_in.q;
      cell_ff.v           <= cell_in.v;
   end

   assign dout = cell_ff;

endmodule

FILE: hw/rtl/cbcr_div_cell.sv
// One quotient bit of both push divisions.
module cbcr_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  cbcr_pkg::dv_type  din,
   output cbcr_pkg::dv_type  dout
);
   import cbcr_pkg::*;

   dv_type            cell_ff, cell_in;
   logic [DIST_W:0]   tx, ty;
   logic              gx, gy;

   always_comb begin
      tx = {din.remx, din.nx[RQ_W-1]};
      ty = {din.remy, din.ny[RQ_W-1]};
      gx = tx >= (DIST_W+1)'(din.dvsr);
      gy = ty >= (DIST_W+1)'(din.dvsr);
      cell_in.side = din.side;
      cell_in.dvsr = din.dvsr;
      cell_in.remx = gx ? DIST_W'(tx - (DIST_W+1)'(din.dvsr)) : DIST_W'(tx);
      cell_in.remy = gy ? DIST_W'(ty - (DIST_W+1)'(din.dvsr)) : DIST_W'(ty);
      cell_in.nx   = {din.nx[RQ_W-2:0], 1'b0};
      cell_in.ny   = {din.ny[RQ_W-2:0], 1'b0};
      cell_in.qx   = {din.qx[RQ_W-2:0], gx};
      cell_in.qy   = {din.qy[RQ_W-2:0], gy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.side.valid <= 1'b0;
      end else begin
         cell_ff.side.valid <= cell_in.side.valid;
      end
      cell_ff.side.hit    <= cell_in.side.hit;
      cell_ff.side.in_box <= cell_in.side.in_box;
      cell_ff.side.sx     <= cell_in.side.sx;
      cell_ff.side.sy     <= cell_in.side.sy;
      cell_ff.side.adx    <= cell_in.side.adx;
      cell_ff.side.ady    <= cell_in.side.ady;
      cell_ff.side.rq     <= cell_in.side.rq;
      cell_ff.side.ipx    <= cell_in.side.ipx;
      cell_ff.side.ipy    <= cell_in.side.ipy;
      cell_ff.dvsr        <= cell_in.dvsr;
      cell_ff.remx        <= cell_in.remx;
      cell_ff.remy        <= cell_in.remy;
      cell_ff.nx          <= cell_in.nx;
      cell_ff.ny          <= cell_in.ny;
      cell_ff.qx          <= cell_in.qx;
      cell_ff.qy          <= cell_in.qy;
   end

   assign dout = cell_ff;

endmodule
